>>> sv/ogws_pkg.sv
// Shared types and constants for the outlier-gated window statistics unit.
// Holds the controller/datapath command and status structs and the result layout.
// No dependencies.
package ogws_pkg;

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int MEAN_W      = 32;
   localparam int VAR_W       = 48;
   localparam int GATE_W      = 8;
   localparam int MINB_W      = 5;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;

   // Window geometry
   localparam int DEPTH   = 16;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   // Window sum: DEPTH samples of SAMPLE_W bits
   localparam int SUM_MAG_W = SAMPLE_W + ADDR_W;
   localparam int SUM_W     = SUM_MAG_W + 1;

   // Shared serial divider
   localparam int DIV_W       = VAR_W;
   localparam int DIVISOR_W   = $clog2(DEPTH + 2);
   localparam int STEP_W      = $clog2(DIV_W + 1);
   localparam int DIFF_MAG_W  = MEAN_W + 1;
   localparam int WMEAN_MAG_W = SUM_MAG_W + FRAC_W;

   localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(DIFF_MAG_W);
   localparam logic [STEP_W-1:0] VAR_STEPS   = STEP_W'(VAR_W);
   localparam logic [STEP_W-1:0] WMEAN_STEPS = STEP_W'(WMEAN_MAG_W);

   // Register reset values
   localparam logic [GATE_W-1:0] GATE_RESET = 8'd24;
   localparam logic [MINB_W-1:0] MINB_RESET = 5'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GATE_FACTOR     = 1'b0,
      REG_MIN_BEFORE_GATE = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      DIV_OP_MEAN,
      DIV_OP_VAR,
      DIV_OP_WMEAN
   } div_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_DEV,
      ST_SQUARE,
      ST_VAR_START,
      ST_VAR_WAIT,
      ST_GATE_MUL,
      ST_GATE,
      ST_WALK,
      ST_DRAIN,
      ST_WMEAN_START,
      ST_WMEAN_WAIT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic               take_sample;
      logic               div_start;
      div_op_type         div_op;
      logic               mean_upd;
      logic               dev_calc;
      logic               square;
      logic               var_upd;
      logic               gate_mul;
      logic               gate_commit;
      logic               walk_clear;
      logic               ring_rd;
      logic [ADDR_W-1:0]  ring_addr;
      logic               wmean_upd;
      logic               out_load;
   } cmd_type;

   typedef struct packed {
      logic               div_busy;
      logic               div_done;
      logic [COUNT_W-1:0] count;
   } status_type;

   typedef struct packed {
      logic                accepted;
      logic [MEAN_W-1:0]   running_mean;
      logic [VAR_W-1:0]    running_variance;
      logic [COUNT_W-1:0]  window_count;
      logic [SAMPLE_W-1:0] window_min;
      logic [SAMPLE_W-1:0] window_max;
      logic [MEAN_W-1:0]   window_mean;
   } result_type;

endpackage

>>> sv/ogws_div.sv
// Radix-2 restoring divider shared by the three divisions of one sample.
// The dividend arrives left-aligned; one quotient bit is produced per cycle.
// Depends on ogws_pkg.
module ogws_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ogws_pkg::DIV_W-1:0]     dividend,
   input  logic [ogws_pkg::DIVISOR_W-1:0] divisor,
   input  logic [ogws_pkg::STEP_W-1:0]    steps,
   output logic                           busy,
   output logic                           done,
   output logic [ogws_pkg::DIV_W-1:0]     quotient
);
   import ogws_pkg::*;

   logic [STEP_W-1:0]    steps_left_ff, steps_left_in;
   logic                 done_ff, done_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   trial_sub;
   logic                 fits;

   // Partial remainder stays below the divisor, so one extra bit holds the trial.
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign fits      = trial >= {1'b0, divisor};

   always_comb begin
      steps_left_in = steps_left_ff;
      done_in       = 1'b0;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      if (start) begin
         steps_left_in = steps;
         quo_in        = dividend;
         rem_in        = '0;
      end else if (steps_left_ff != '0) begin
         steps_left_in = steps_left_ff - STEP_W'(1);
         done_in       = (steps_left_ff == STEP_W'(1));
         quo_in        = {quo_ff[DIV_W-2:0], fits};
         rem_in        = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_left_ff <= '0;
         done_ff       <= 1'b0;
      end else begin
         steps_left_ff <= steps_left_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = (steps_left_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/ogws_dp.sv
// Datapath: running statistics registers, sample ring, gate and window walk.
// Acts on commands from ogws_ctrl and on direct register writes; instantiates ogws_div.
// Depends on ogws_pkg and ogws_div.
module ogws_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  ogws_pkg::cmd_type                cmd,
   output ogws_pkg::status_type             status,
   input  logic                             csr_we,
   input  logic [ogws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ogws_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [ogws_pkg::SAMPLE_W-1:0]    req_sample,
   output ogws_pkg::result_type             result
);
   import ogws_pkg::*;

   localparam int MEAN_EXT_W = 40;
   localparam int GMUL_W     = VAR_W + GATE_W;

   // Saturates a sign-extended value to the signed 32-bit range.
   function automatic logic [MEAN_W-1:0] sat_mean(input logic signed [MEAN_EXT_W-1:0] v);
      logic signed [MEAN_EXT_W-1:0] hi;
      logic signed [MEAN_EXT_W-1:0] lo;
      hi = MEAN_EXT_W'(signed'({1'b0, {(MEAN_W-1){1'b1}}}));
      lo = -hi - MEAN_EXT_W'(1);
      if (v > hi) begin
         sat_mean = hi[MEAN_W-1:0];
      end else if (v < lo) begin
         sat_mean = lo[MEAN_W-1:0];
      end else begin
         sat_mean = v[MEAN_W-1:0];
      end
   endfunction

   // Control and architectural state
   logic [GATE_W-1:0]  gate_ff, gate_in;
   logic [MINB_W-1:0]  minb_ff, minb_in;
   logic [MEAN_W-1:0]  mean_ff, mean_in;
   logic [VAR_W-1:0]   var_ff, var_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]  slot_ff, slot_in;
   logic               rd_pend_ff;

   // Working registers
   logic [SAMPLE_W-1:0]        sample_ff;
   logic                       neg_ff;
   logic [MEAN_W-1:0]          mag_ff;
   logic [VAR_W-1:0]           d_ff;
   logic [GMUL_W-1:0]          rhs_ff;
   logic                       accept_ff;
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] wmin_ff;
   logic signed [SAMPLE_W-1:0] wmax_ff;
   logic [MEAN_W-1:0]          wmean_ff;
   result_type                 result_ff;

   logic [SAMPLE_W-1:0] ring_mem [DEPTH];

   // Divider hookup
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [STEP_W-1:0]    div_steps;
   logic                 div_busy;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quotient;

   // Combinational helpers
   logic signed [MEAN_W+1:0]     mean_diff;
   logic [MEAN_W+1:0]            mean_diff_abs;
   logic signed [SUM_W-1:0]      sum_neg;
   logic [SUM_MAG_W-1:0]         sum_abs;
   logic [DIFF_MAG_W-1:0]        mean_q;
   logic signed [MEAN_EXT_W-1:0] mean_q_s;
   logic signed [MEAN_EXT_W-1:0] mean_sum;
   logic [WMEAN_MAG_W-1:0]       wmean_q;
   logic signed [MEAN_EXT_W-1:0] wmean_q_s;
   logic [VAR_W:0]               var_sum;
   logic [2*MEAN_W-1:0]          square_prod;
   logic                         accept;
   logic signed [SAMPLE_W-1:0]   rd_value;

   // Sample in Q16.16 minus the current mean, two guard bits wide.
   assign mean_diff     = signed'({{2{sample_ff[SAMPLE_W-1]}}, sample_ff, {FRAC_W{1'b0}}})
                        - signed'({{2{mean_ff[MEAN_W-1]}}, mean_ff});
   assign mean_diff_abs = mean_diff[MEAN_W+1] ? (~mean_diff + 1'b1) : mean_diff;

   assign sum_neg = -sum_ff;
   assign sum_abs = sum_ff[SUM_W-1] ? sum_neg[SUM_MAG_W-1:0] : sum_ff[SUM_MAG_W-1:0];

   always_comb begin
      div_dividend = '0;
      div_divisor  = DIVISOR_W'(count_ff) + DIVISOR_W'(1);
      div_steps    = VAR_STEPS;
      unique case (cmd.div_op)
         DIV_OP_MEAN: begin
            div_dividend = {mean_diff_abs[DIFF_MAG_W-1:0], {(DIV_W-DIFF_MAG_W){1'b0}}};
            div_steps    = MEAN_STEPS;
         end
         DIV_OP_VAR: begin
            div_dividend = d_ff;
            div_steps    = VAR_STEPS;
         end
         DIV_OP_WMEAN: begin
            div_dividend = {sum_abs, {FRAC_W{1'b0}}, {(DIV_W-WMEAN_MAG_W){1'b0}}};
            div_divisor  = DIVISOR_W'(count_ff);
            div_steps    = WMEAN_STEPS;
         end
         default: begin
            div_dividend = '0;
         end
      endcase
   end

   ogws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Quotients re-signed and added.
   assign mean_q    = div_quotient[DIFF_MAG_W-1:0];
   assign mean_q_s  = neg_ff ? -signed'(MEAN_EXT_W'(mean_q)) : signed'(MEAN_EXT_W'(mean_q));
   assign mean_sum  = MEAN_EXT_W'(signed'(mean_ff)) + mean_q_s;
   assign wmean_q   = div_quotient[WMEAN_MAG_W-1:0];
   assign wmean_q_s = neg_ff ? -signed'(MEAN_EXT_W'(wmean_q)) : signed'(MEAN_EXT_W'(wmean_q));
   assign var_sum   = {1'b0, var_ff} + {1'b0, div_quotient};

   assign square_prod = (2*MEAN_W)'(mag_ff) * (2*MEAN_W)'(mag_ff);

   // Gate: pass below min count, or if deviation^2 x 16 < gate factor x variance.
   assign accept = (count_ff < COUNT_W'(minb_ff))
                || ({{(GMUL_W-VAR_W-4){1'b0}}, d_ff, 4'b0000} < rhs_ff);

   assign rd_value = signed'(rd_data_ff);

   always_comb begin
      gate_in  = gate_ff;
      minb_in  = minb_ff;
      mean_in  = mean_ff;
      var_in   = var_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_GATE_FACTOR:     gate_in = csr_wdata[GATE_W-1:0];
            REG_MIN_BEFORE_GATE: minb_in = csr_wdata[MINB_W-1:0];
            default:             gate_in = gate_ff;
         endcase
      end
      if (cmd.mean_upd) begin
         mean_in = sat_mean(mean_sum);
      end
      if (cmd.var_upd) begin
         var_in = var_sum[VAR_W] ? {VAR_W{1'b1}} : var_sum[VAR_W-1:0];
      end
      if (cmd.gate_commit && accept) begin
         if (count_ff != COUNT_W'(DEPTH)) begin
            count_in = count_ff + COUNT_W'(1);
         end
         slot_in = (slot_ff == ADDR_W'(DEPTH - 1)) ? '0 : slot_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff    <= GATE_RESET;
         minb_ff    <= MINB_RESET;
         mean_ff    <= '0;
         var_ff     <= '0;
         count_ff   <= '0;
         slot_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         gate_ff    <= gate_in;
         minb_ff    <= minb_in;
         mean_ff    <= mean_in;
         var_ff     <= var_in;
         count_ff   <= count_in;
         slot_ff    <= slot_in;
         rd_pend_ff <= cmd.ring_rd;
      end
   end

   // Sample ring: one write on an accepted commit, one registered read per walk step.
   always_ff @(posedge clock) begin
      if (cmd.gate_commit && accept) begin
         ring_mem[slot_ff] <= sample_ff;
      end
      if (cmd.ring_rd) begin
         rd_data_ff <= ring_mem[cmd.ring_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         sample_ff <= req_sample;
      end
      if (cmd.div_start && (cmd.div_op == DIV_OP_MEAN)) begin
         neg_ff <= mean_diff[MEAN_W+1];
      end else if (cmd.div_start && (cmd.div_op == DIV_OP_WMEAN)) begin
         neg_ff <= sum_ff[SUM_W-1];
      end
      if (cmd.dev_calc) begin
         mag_ff <= mean_diff_abs[MEAN_W] ? {MEAN_W{1'b1}} : mean_diff_abs[MEAN_W-1:0];
      end
      if (cmd.square) begin
         d_ff <= square_prod[2*MEAN_W-1:FRAC_W];
      end
      if (cmd.gate_mul) begin
         rhs_ff <= GMUL_W'(gate_ff) * GMUL_W'(var_ff);
      end
      if (cmd.gate_commit) begin
         accept_ff <= accept;
      end
      if (cmd.walk_clear) begin
         sum_ff  <= '0;
         wmin_ff <= signed'({1'b0, {(SAMPLE_W-1){1'b1}}});
         wmax_ff <= signed'({1'b1, {(SAMPLE_W-1){1'b0}}});
      end else if (rd_pend_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_value);
         if (rd_value < wmin_ff) begin
            wmin_ff <= rd_value;
         end
         if (rd_value > wmax_ff) begin
            wmax_ff <= rd_value;
         end
      end
      if (cmd.wmean_upd) begin
         wmean_ff <= sat_mean(wmean_q_s);
      end
      if (cmd.out_load) begin
         result_ff.accepted         <= accept_ff;
         result_ff.running_mean     <= mean_ff;
         result_ff.running_variance <= var_ff;
         result_ff.window_count     <= count_ff;
         if (count_ff == '0) begin
            result_ff.window_min  <= '0;
            result_ff.window_max  <= '0;
            result_ff.window_mean <= '0;
         end else begin
            result_ff.window_min  <= wmin_ff;
            result_ff.window_max  <= wmax_ff;
            result_ff.window_mean <= wmean_ff;
         end
      end
   end

   assign status.div_busy = div_busy;
   assign status.div_done = div_done;
   assign status.count    = count_ff;
   assign result          = result_ff;

   // The fill count never passes the ring depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("window count exceeds ring depth");

   // The variance accumulator only grows.
   a_var_monotone: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> var_ff >= $past(var_ff))
      else $error("variance accumulator decreased");

   // A non-empty window reports a minimum no larger than its maximum.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && (count_ff != '0)
      |=> $signed(result_ff.window_min) <= $signed(result_ff.window_max))
      else $error("window minimum above window maximum");

endmodule

>>> sv/ogws_ctrl.sv
// Sequencer for the outlier-gated window statistics unit.
// Steps one sample through the datapath and owns both stream handshakes.
// Depends on ogws_pkg.
module ogws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ogws_pkg::status_type status,
   output ogws_pkg::cmd_type    cmd
);
   import ogws_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] walk_ff, walk_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      walk_in    = walk_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_sample = 1'b1;
               state_in        = ST_MEAN_START;
            end
         end
         ST_MEAN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_OP_MEAN;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.mean_upd = 1'b1;
               state_in     = ST_DEV;
            end
         end
         ST_DEV: begin
            cmd.dev_calc = 1'b1;
            state_in     = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_VAR_START;
         end
         ST_VAR_START: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_OP_VAR;
            state_in      = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            cmd.div_op = DIV_OP_VAR;
            if (status.div_done) begin
               cmd.var_upd = 1'b1;
               state_in    = ST_GATE_MUL;
            end
         end
         ST_GATE_MUL: begin
            cmd.gate_mul = 1'b1;
            state_in     = ST_GATE;
         end
         ST_GATE: begin
            cmd.gate_commit = 1'b1;
            cmd.walk_clear  = 1'b1;
            walk_in         = '0;
            state_in        = ST_WALK;
         end
         ST_WALK: begin
            if (status.count == '0) begin
               state_in = ST_OUTPUT;
            end else begin
               cmd.ring_rd   = 1'b1;
               cmd.ring_addr = walk_ff[ADDR_W-1:0];
               walk_in       = walk_ff + COUNT_W'(1);
               if (walk_ff + COUNT_W'(1) == status.count) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_WMEAN_START;
         end
         ST_WMEAN_START: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = DIV_OP_WMEAN;
            state_in      = ST_WMEAN_WAIT;
         end
         ST_WMEAN_WAIT: begin
            cmd.div_op = DIV_OP_WMEAN;
            if (status.div_done) begin
               cmd.wmean_upd = 1'b1;
               state_in      = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // A new result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before transfer");

   // The shared divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   // A waiting result stays valid until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("result valid dropped before transfer");

endmodule

>>> sv/outlier_gated_window_stats_unit.sv
// Top level of the outlier-gated window statistics unit.
// Joins the sequencer (ogws_ctrl) and the datapath (ogws_dp) and packs the streams.
// Depends on ogws_pkg, ogws_ctrl, ogws_dp and, through the datapath, ogws_div.
//
//  Channel   Direction  Payload                                        Handshake
//  --------  ---------  ---------------------------------------------  -------------------
//  req_      in         tdata[15:0] sample                             tvalid / tready
//  rsp_      out        tdata[149:0] result fields, see port comment   tvalid / tready
//  csr_      in         wdata[7:0] to register csr_index               csr_we, no wait
//
// From the transfer of a sample on req_ to the earliest transfer of its result on rsp_,
// most of the time goes to the single radix-2 divider shared by three divisions (33, 48
// and 36 quotient bits); the window walk adds one ring read per stored entry. When the
// window is empty after the gate, the walk and the window-mean division are skipped.
// A sample is taken only while the sequencer is idle; the next one may be taken while
// the previous result still sits in the output register.
// Reset is synchronous and active high; it clears the running mean, variance, fill
// count and write slot and restores the register defaults. The ring needs no clearing.
// A stalled rsp_ side holds the finished result and holds the sequencer in its final
// step; the input side then stalls once the following sample is under way.
module outlier_gated_window_stats_unit (
   input  logic         clock,
   input  logic         reset,

   // Input stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [15:0] sample

   // Result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // [0] accepted, [32:1] running_mean,
                                     // [80:33] running_variance, [85:81] window_count,
                                     // [101:86] window_min, [117:102] window_max,
                                     // [149:118] window_mean, [151:150] zero

   // Configuration writes
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_wdata
);
   import ogws_pkg::*;

   localparam int RSP_FIELDS_W = 1 + MEAN_W + VAR_W + COUNT_W + 2*SAMPLE_W + MEAN_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   cmd_type    cmd;
   status_type status;
   result_type result;

   // The sequencer drives every step of the datapath and both handshakes.
   ogws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the statistics, the ring and the output register.
   ogws_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_sample (req_tdata[SAMPLE_W-1:0]),
      .result     (result)
   );

   // Fields packed from the lowest bit up, padded with zeros to whole bytes.
   assign rsp_tdata = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}},
                       result.window_mean,
                       result.window_max,
                       result.window_min,
                       result.window_count,
                       result.running_variance,
                       result.running_mean,
                       result.accepted};

endmodule
